FILE: design/crf_pkg.sv
// ----------------------------------------------------------------------------
// crf_pkg: shared types and constants of the clipped rectangle fill engine
// Frame size defaults, command codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package crf_pkg;

   // default frame geometry
   localparam int FRAME_WIDTH_DEF  = 320;
   localparam int FRAME_HEIGHT_DEF = 200;

   // field widths fixed by the command format
   localparam int COORD_W = 16;
   localparam int COLOR_W = 8;
   localparam int STAT_W  = 2;

   // clipping arithmetic width: holds any sum of two coordinates, signed
   localparam int SUM_W = COORD_W + 2;

   typedef enum logic {
      CMD_FILL = 1'b0,
      CMD_READ = 1'b1
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_FILLED    = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_READ_DONE = 2'd2,
      STAT_READ_OUT  = 2'd3
   } status_type;

endpackage

`default_nettype wire

FILE: design/crf_frame_ram.sv
// ----------------------------------------------------------------------------
// crf_frame_ram: frame store
// Single-port synchronous memory, one pixel per entry, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_frame_ram
   import crf_pkg::*;
#(
   parameter int DEPTH  = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic               we,
   input  wire logic [ADDR_W-1:0]  addr,
   input  wire logic [COLOR_W-1:0] wdata,
   output logic      [COLOR_W-1:0] rdata
);

   logic [COLOR_W-1:0] mem [DEPTH];
   logic [COLOR_W-1:0] rdata_ff;

   // write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: design/clipped_rect_fill_engine.sv
// ----------------------------------------------------------------------------
// clipped_rect_fill_engine: indexed frame store with clipped rectangle fill
// A fill transaction clips a signed rectangle to the frame and writes every
// covered pixel row by row; a read transaction returns one pixel.
//
//   channel   ports                                    handshake
//   request   req_command, req_origin_x/y,             start high, busy low
//             req_extent_w/h, req_fill_color
//   response  rsp_pixel_value, rsp_status              rsp_valid, one cycle
//
// Steps: a fill passes S_CLIP, S_TRIM and S_BASE, then S_FILL writes one pixel
// per cycle through the single frame memory port. A fill clipped to nothing
// responds from S_BASE; a read inside the frame goes on through S_READ and
// S_RDATA for the registered memory data; a read outside responds from S_CLIP.
// The response appears in the same cycle that busy falls; a new transaction may
// be started in that cycle. Reset clears control only; the frame memory holds
// garbage until written. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_rect_fill_engine
   import crf_pkg::*;
#(
   parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_command,
   input  wire logic signed [COORD_W-1:0] req_origin_x,
   input  wire logic signed [COORD_W-1:0] req_origin_y,
   input  wire logic signed [COORD_W-1:0] req_extent_w,
   input  wire logic signed [COORD_W-1:0] req_extent_h,
   input  wire logic        [COLOR_W-1:0] req_fill_color,
   output logic                           rsp_valid,
   output logic             [COLOR_W-1:0] rsp_pixel_value,
   output logic             [STAT_W-1:0]  rsp_status
);

   localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int COL_W  = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
   localparam int ROW_W  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

   localparam logic signed [SUM_W-1:0] FW_S = SUM_W'(FRAME_WIDTH);
   localparam logic signed [SUM_W-1:0] FH_S = SUM_W'(FRAME_HEIGHT);
   localparam logic        [ADDR_W-1:0] FW_A = ADDR_W'(FRAME_WIDTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLIP,
      S_TRIM,
      S_BASE,
      S_FILL,
      S_READ,
      S_RDATA
   } state_type;

   state_type               state_ff, state_in;
   command_type             cmd_ff, cmd_in;
   logic signed [SUM_W-1:0] px_ff, px_in;
   logic signed [SUM_W-1:0] py_ff, py_in;
   logic signed [SUM_W-1:0] ew_ff, ew_in;
   logic signed [SUM_W-1:0] eh_ff, eh_in;
   logic [COLOR_W-1:0]      color_ff, color_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [ADDR_W-1:0]       row_base_ff, row_base_in;
   logic [COL_W-1:0]        col_left_ff, col_left_in;
   logic [COL_W-1:0]        col_last_ff, col_last_in;
   logic [ROW_W-1:0]        row_left_ff, row_left_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]      rsp_pixel_ff, rsp_pixel_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic                    ram_en;
   logic                    ram_we;
   logic [COLOR_W-1:0]      ram_rdata;

   logic                    in_frame;
   logic signed [SUM_W-1:0] end_x;
   logic signed [SUM_W-1:0] end_y;
   logic [ADDR_W-1:0]       base_addr;
   logic [ADDR_W-1:0]       next_row_base;

   // frame memory
   crf_frame_ram #(
      .DEPTH  (PIXELS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (addr_ff),
      .wdata (color_ff),
      .rdata (ram_rdata)
   );

   // clip and address arithmetic
   assign in_frame = (px_ff >= 0) && (px_ff < FW_S) && (py_ff >= 0) && (py_ff < FH_S);
   assign end_x    = px_ff + ew_ff;
   assign end_y    = py_ff + eh_ff;
   // origin is inside the frame whenever this is used, so truncation is exact
   assign base_addr     = ADDR_W'(py_ff) * FW_A + ADDR_W'(px_ff);
   assign next_row_base = row_base_ff + FW_A;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      ew_in         = ew_ff;
      eh_in         = eh_ff;
      color_in      = color_ff;
      addr_in       = addr_ff;
      row_base_in   = row_base_ff;
      col_left_in   = col_left_ff;
      col_last_in   = col_last_ff;
      row_left_in   = row_left_ff;
      rsp_valid_in  = 1'b0;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_status_in = rsp_status_ff;
      ram_en        = 1'b0;
      ram_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // capture the transaction
            if (start) begin
               cmd_in   = command_type'(req_command);
               px_in    = SUM_W'(req_origin_x);
               py_in    = SUM_W'(req_origin_y);
               ew_in    = SUM_W'(req_extent_w);
               eh_in    = SUM_W'(req_extent_h);
               color_in = req_fill_color;
               state_in = S_CLIP;
            end
         end
         S_CLIP: begin
            if (cmd_ff == CMD_READ) begin
               if (in_frame) begin
                  state_in = S_BASE;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_pixel_in  = '0;
                  rsp_status_in = STAT_READ_OUT;
                  state_in      = S_IDLE;
               end
            end else begin
               // shrink the extent by a negative origin
               if (px_ff < 0) begin
                  ew_in = ew_ff + px_ff;
                  px_in = '0;
               end
               if (py_ff < 0) begin
                  eh_in = eh_ff + py_ff;
                  py_in = '0;
               end
               state_in = S_TRIM;
            end
         end
         S_TRIM: begin
            // cut at the right and bottom edges
            if (end_x > FW_S) begin
               ew_in = FW_S - px_ff;
            end
            if (end_y > FH_S) begin
               eh_in = FH_S - py_ff;
            end
            state_in = S_BASE;
         end
         S_BASE: begin
            if (cmd_ff == CMD_READ) begin
               addr_in  = base_addr;
               state_in = S_READ;
            end else if ((ew_ff <= 0) || (eh_ff <= 0)) begin
               rsp_valid_in  = 1'b1;
               rsp_pixel_in  = '0;
               rsp_status_in = STAT_EMPTY;
               state_in      = S_IDLE;
            end else begin
               addr_in     = base_addr;
               row_base_in = base_addr;
               col_last_in = COL_W'(ew_ff - SUM_W'(1));
               col_left_in = COL_W'(ew_ff - SUM_W'(1));
               row_left_in = ROW_W'(eh_ff - SUM_W'(1));
               state_in    = S_FILL;
            end
         end
         S_FILL: begin
            // write one pixel, advance along the row, then to the next row
            ram_en = 1'b1;
            ram_we = 1'b1;
            if (col_left_ff == '0) begin
               if (row_left_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_pixel_in  = '0;
                  rsp_status_in = STAT_FILLED;
                  state_in      = S_IDLE;
               end else begin
                  row_base_in = next_row_base;
                  addr_in     = next_row_base;
                  col_left_in = col_last_ff;
                  row_left_in = row_left_ff - ROW_W'(1);
               end
            end else begin
               addr_in     = addr_ff + ADDR_W'(1);
               col_left_in = col_left_ff - COL_W'(1);
            end
         end
         S_READ: begin
            ram_en   = 1'b1;
            state_in = S_RDATA;
         end
         S_RDATA: begin
            rsp_valid_in  = 1'b1;
            rsp_pixel_in  = ram_rdata;
            rsp_status_in = STAT_READ_DONE;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      ew_ff         <= ew_in;
      eh_ff         <= eh_in;
      color_ff      <= color_in;
      addr_ff       <= addr_in;
      row_base_ff   <= row_base_in;
      col_left_ff   <= col_left_in;
      col_last_ff   <= col_last_in;
      row_left_ff   <= row_left_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   // a response is a single-cycle strobe
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // an accepted transaction makes the engine busy
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction accepted but engine not busy");

   // fill results carry a zero pixel value
   a_fill_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == STAT_FILLED) || (rsp_status == STAT_EMPTY)))
      |-> (rsp_pixel_value == '0))
      else $error("fill response with nonzero pixel value");

   // memory writes happen only inside a fill
   a_write_busy : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (busy && ram_en && (cmd_ff == CMD_FILL)))
      else $error("frame memory written outside a fill");
`endif

endmodule

`default_nettype wire

FILE: dv/clipped_rect_fill_engine_tb.sv
// ----------------------------------------------------------------------------
// clipped_rect_fill_engine_tb: self-checking bench for the rectangle fill engine
// Directed fills and reads cover clipping at every frame edge, extreme
// coordinates, empty rectangles and out-of-frame reads. Random transactions
// follow, most of them small fills near the frame edges and reads back of
// pixels already drawn. A frame model in the bench predicts each response,
// and a monitor compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_rect_fill_engine_tb;
   import crf_pkg::*;

   localparam int FRAME_W      = FRAME_WIDTH_DEF;
   localparam int FRAME_H      = FRAME_HEIGHT_DEF;
   localparam int FRAME_PIXELS = FRAME_W * FRAME_H;
   localparam int RANDOM_ITEMS = 80;
   // a full-frame fill is the longest quiet stretch on both channels
   localparam int IDLE_LIMIT   = 4 * FRAME_PIXELS;
   localparam int TAIL_CYCLES  = 16;

   typedef struct {
      command_type              command;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] extent_w;
      logic signed [COORD_W-1:0] extent_h;
      logic        [COLOR_W-1:0] fill_color;
      bit                        drain_first;
   } draw_request_type;

   typedef struct {
      logic [COLOR_W-1:0] pixel_value;
      status_type         status;
   } pixel_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_command = 1'b0;
   logic signed [COORD_W-1:0] req_origin_x = '0;
   logic signed [COORD_W-1:0] req_origin_y = '0;
   logic signed [COORD_W-1:0] req_extent_w = '0;
   logic signed [COORD_W-1:0] req_extent_h = '0;
   logic        [COLOR_W-1:0] req_fill_color = '0;
   logic                      rsp_valid;
   logic        [COLOR_W-1:0] rsp_pixel_value;
   logic        [STAT_W-1:0]  rsp_status;

   // frame model and bookkeeping
   logic [COLOR_W-1:0] frame_model [0:FRAME_PIXELS-1];
   draw_request_type   command_q [$];
   pixel_result_type   predicted_q [$];
   draw_request_type   active_cmd;
   int                 total_cmds = 0;
   int                 accepted_cmds = 0;
   int                 burst_left = 1;
   int                 gap_left = 0;
   int                 idle_cycles = 0;
   int                 error_count = 0;
   int                 fills_drawn = 0;
   int                 fills_empty = 0;
   int                 reads_inside = 0;
   int                 reads_outside = 0;
   longint             pixels_written = 0;

   clipped_rect_fill_engine DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_origin_x   (req_origin_x),
      .req_origin_y   (req_origin_y),
      .req_extent_w   (req_extent_w),
      .req_extent_h   (req_extent_h),
      .req_fill_color (req_fill_color),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_value(rsp_pixel_value),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Clip a rectangle to the frame; return the covered pixel count, 0 if none.
   function automatic longint clip_rect(input draw_request_type r, output longint cx,
                                        output longint cy, output longint cw,
                                        output longint ch);
      cx = longint'(r.origin_x);
      cy = longint'(r.origin_y);
      cw = longint'(r.extent_w);
      ch = longint'(r.extent_h);
      if (cx < 0) begin
         cw += cx;
         cx = 0;
      end
      if (cy < 0) begin
         ch += cy;
         cy = 0;
      end
      if (cx + cw > FRAME_W) cw = FRAME_W - cx;
      if (cy + ch > FRAME_H) ch = FRAME_H - cy;
      if (cw <= 0 || ch <= 0) return 0;
      return cw * ch;
   endfunction

   // Execute one transaction on the frame model and return its response.
   function automatic pixel_result_type draw_and_predict(input draw_request_type r);
      pixel_result_type res;
      longint           cx, cy, cw, ch, area;
      res.pixel_value = '0;
      if (r.command == CMD_READ) begin
         cx = longint'(r.origin_x);
         cy = longint'(r.origin_y);
         if (cx >= 0 && cx < FRAME_W && cy >= 0 && cy < FRAME_H) begin
            res.pixel_value = frame_model[cy * FRAME_W + cx];
            res.status      = STAT_READ_DONE;
         end else begin
            res.status = STAT_READ_OUT;
         end
      end else begin
         area = clip_rect(r, cx, cy, cw, ch);
         if (area == 0) begin
            res.status = STAT_EMPTY;
         end else begin
            for (longint row = cy; row < cy + ch; row++)
               for (longint col = cx; col < cx + cw; col++)
                  frame_model[row * FRAME_W + col] = r.fill_color;
            pixels_written += area;
            res.status = STAT_FILLED;
         end
      end
      return res;
   endfunction

   task automatic add_request(input command_type cmd, input int x, input int y,
                              input int w, input int h, input int color,
                              input bit drain);
      draw_request_type r;
      r.command     = cmd;
      r.origin_x    = x[COORD_W-1:0];
      r.origin_y    = y[COORD_W-1:0];
      r.extent_w    = w[COORD_W-1:0];
      r.extent_h    = h[COORD_W-1:0];
      r.fill_color  = color[COLOR_W-1:0];
      r.drain_first = drain;
      command_q.push_back(r);
   endtask

   // Driver: issue queued transactions in random bursts, hold while busy.
   always @(posedge clock) begin
      pixel_result_type res;
      if (reset) begin
         start <= 1'b0;
      end else begin
         // record an accepted transaction and predict its response
         if (start && !busy) begin
            res = draw_and_predict(active_cmd);
            predicted_q.push_back(res);
            accepted_cmds++;
            case (res.status)
               STAT_FILLED:    fills_drawn++;
               STAT_EMPTY:     fills_empty++;
               STAT_READ_DONE: reads_inside++;
               STAT_READ_OUT:  reads_outside++;
               default: begin
               end
            endcase
         end
         if (start && busy) begin
            // hold the request until the engine takes it
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (command_q.size() == 0 ||
                      (command_q[0].drain_first && predicted_q.size() != 0)) begin
            start <= 1'b0;
         end else begin
            active_cmd     = command_q.pop_front();
            req_command    <= active_cmd.command;
            req_origin_x   <= active_cmd.origin_x;
            req_origin_y   <= active_cmd.origin_y;
            req_extent_w   <= active_cmd.extent_w;
            req_extent_h   <= active_cmd.extent_h;
            req_fill_color <= active_cmd.fill_color;
            start          <= 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               // pick the next burst; some have no gap at all
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(1, 6);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // Monitor: compare each response with the oldest prediction.
   always @(posedge clock) begin
      pixel_result_type exp_res;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            if (predicted_q.size() == 0) begin
               $error("unexpected response: pixel_value %0d status %0d",
                      rsp_pixel_value, rsp_status);
               error_count++;
            end else begin
               exp_res = predicted_q.pop_front();
               if (rsp_pixel_value !== exp_res.pixel_value) begin
                  $error("pixel_value: expected %0d, actual %0d",
                         exp_res.pixel_value, rsp_pixel_value);
                  error_count++;
               end
               if (rsp_status !== exp_res.status) begin
                  $error("status: expected %0d, actual %0d", exp_res.status, rsp_status);
                  error_count++;
               end
            end
         end
      end
   end

   // Build the stimulus, then wait for the run to settle and report.
   initial begin
      int               i, pick;
      bit               drain;
      draw_request_type r;
      longint           dx, dy, dw, dh;
      bit               timed_out;
      int               leftover;

      // clear the whole frame first so that every later read hits a drawn pixel
      add_request(CMD_FILL, 0, 0, FRAME_W, FRAME_H, 8'h5A, 1'b0);
      add_request(CMD_READ, 0, 0, 0, 0, 0, 1'b1);
      add_request(CMD_READ, FRAME_W - 1, FRAME_H - 1, 0, 0, 0, 1'b0);
      // single pixel
      add_request(CMD_FILL, 5, 7, 1, 1, 8'hFF, 1'b0);
      add_request(CMD_READ, 5, 7, 0, 0, 0, 1'b0);
      // horizontal line cut at the left and right edges
      add_request(CMD_FILL, -10, 3, 400, 1, 8'hA5, 1'b0);
      add_request(CMD_READ, 0, 3, 0, 0, 0, 1'b0);
      add_request(CMD_READ, FRAME_W - 1, 3, 0, 0, 0, 1'b0);
      // vertical line cut at the top and bottom edges
      add_request(CMD_FILL, FRAME_W - 1, -5, 1, 32767, 8'h3C, 1'b0);
      add_request(CMD_READ, FRAME_W - 1, FRAME_H - 1, 0, 0, 0, 1'b0);
      // rectangles that clip to nothing
      add_request(CMD_FILL, 10, 10, 0, 5, 8'h11, 1'b0);
      add_request(CMD_FILL, 10, 10, -1, 5, 8'h22, 1'b0);
      add_request(CMD_FILL, 10, 10, 5, -32768, 8'h33, 1'b0);
      add_request(CMD_FILL, FRAME_W, 0, 10, 10, 8'h44, 1'b0);
      add_request(CMD_FILL, 0, FRAME_H, 10, 10, 8'h55, 1'b0);
      add_request(CMD_FILL, 32767, 32767, 32767, 32767, 8'h66, 1'b0);
      add_request(CMD_FILL, -32768, -32768, 32767, 32767, 8'h77, 1'b0);
      // reads outside the frame
      add_request(CMD_READ, -1, 0, 0, 0, 0, 1'b0);
      add_request(CMD_READ, 0, FRAME_H, 0, 0, 0, 1'b0);
      add_request(CMD_READ, FRAME_W, 0, 0, 0, 0, 1'b0);
      add_request(CMD_READ, -32768, 32767, 0, 0, 0, 1'b0);
      // oversized rectangle from a negative origin covers the whole frame
      add_request(CMD_FILL, -100, -100, 32767, 32767, 8'h00, 1'b0);
      add_request(CMD_READ, FRAME_W / 2, FRAME_H / 2, 0, 0, 0, 1'b0);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         pick  = $urandom_range(0, 99);
         drain = ($urandom_range(0, 24) == 0) || (i == RANDOM_ITEMS / 2);
         if (pick < 30) begin
            add_request(CMD_READ, $urandom_range(0, FRAME_W - 1),
                        $urandom_range(0, FRAME_H - 1), $urandom(), $urandom(),
                        $urandom(), drain);
         end else if (pick < 34) begin
            add_request(CMD_READ, int'($urandom_range(0, FRAME_W + 5)) - 3,
                        int'($urandom_range(0, FRAME_H + 5)) - 3, $urandom(),
                        $urandom(), $urandom(), drain);
         end else if (pick < 38) begin
            add_request(CMD_READ, $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), drain);
         end else if (pick < 83) begin
            // small fill near the frame edges
            add_request(CMD_FILL, int'($urandom_range(0, FRAME_W + 39)) - 20,
                        int'($urandom_range(0, FRAME_H + 39)) - 20,
                        int'($urandom_range(0, 51)) - 3,
                        int'($urandom_range(0, 27)) - 3, $urandom(), drain);
         end else if (pick < 97) begin
            // raw 16-bit fields; drop the few that would cover a large area
            do begin
               r.command     = CMD_FILL;
               r.origin_x    = COORD_W'($urandom());
               r.origin_y    = COORD_W'($urandom());
               r.extent_w    = COORD_W'($urandom());
               r.extent_h    = COORD_W'($urandom());
               r.fill_color  = COLOR_W'($urandom());
               r.drain_first = drain;
            end while (clip_rect(r, dx, dy, dw, dh) > 4096);
            command_q.push_back(r);
         end else begin
            add_request(CMD_FILL, int'($urandom_range(0, 100)) - 60,
                        int'($urandom_range(0, 100)) - 60, $urandom_range(200, 1000),
                        $urandom_range(150, 1000), $urandom(), drain);
         end
      end
      total_cmds = command_q.size();

      // wait for every transaction and response, bounded by the watchdog
      timed_out = 1'b0;
      while (!timed_out && (accepted_cmds != total_cmds || predicted_q.size() != 0)) begin
         @(posedge clock);
         timed_out = (idle_cycles >= IDLE_LIMIT);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      leftover = predicted_q.size();
      if (leftover != 0 && !timed_out)
         $error("%0d predicted responses never arrived", leftover);

      $display("Ran %0d fills (%0d clipped to nothing, %0d pixels drawn),",
               fills_drawn + fills_empty, fills_empty, pixels_written);
      $display("and %0d reads (%0d outside the frame).",
               reads_inside + reads_outside, reads_outside);
      if (timed_out) $display("Stopped by the watchdog after %0d idle cycles.", idle_cycles);
      if (!timed_out && error_count == 0 && leftover == 0) begin
         $display("clipped_rect_fill_engine_tb OK");
      end else begin
         $display("clipped_rect_fill_engine_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
